[hdl/tcp_pkg.sv]
`default_nettype none

package tcp_pkg;

    localparam int NUM_PHASES = 3;

    localparam int STEP_TH_W  = 15;
    localparam int LEVEL_W    = 16;
    localparam int STEP_CNT_W = 4;
    localparam int CNT_W      = 10;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_STEP_TH    = 3'd0,
        REG_OVER_TH    = 3'd1,
        REG_LIMIT_TH   = 3'd2,
        REG_LIMIT_HYST = 3'd3,
        REG_STEP_CNT   = 3'd4,
        REG_OVER_CNT   = 3'd5,
        REG_LIMIT_CNT  = 3'd6
    } reg_idx_t;

    localparam logic [STEP_TH_W-1:0]  RST_STEP_TH    = 15'd32767;
    localparam logic [LEVEL_W-1:0]    RST_OVER_TH    = 16'd65535;
    localparam logic [LEVEL_W-1:0]    RST_LIMIT_TH   = 16'd65535;
    localparam logic [LEVEL_W-1:0]    RST_LIMIT_HYST = 16'd48;
    localparam logic [STEP_CNT_W-1:0] RST_STEP_CNT   = 4'd3;
    localparam logic [CNT_W-1:0]      RST_OVER_CNT   = 10'd50;
    localparam logic [CNT_W-1:0]      RST_LIMIT_CNT  = 10'd50;

    localparam logic [STEP_CNT_W-1:0] STEP_CTR_MAX = '1;
    localparam logic [CNT_W-1:0]      CTR_MAX      = '1;

    typedef struct packed {
        logic [STEP_TH_W-1:0]  step_th;
        logic [LEVEL_W-1:0]    over_th;
        logic [LEVEL_W-1:0]    limit_th;
        logic [LEVEL_W-1:0]    limit_hyst;
        logic [STEP_CNT_W-1:0] step_cnt;
        logic [CNT_W-1:0]      over_cnt;
        logic [CNT_W-1:0]      limit_cnt;
    } cfg_t;

    typedef struct packed {
        logic [STEP_CNT_W-1:0] step_ctr;
        logic [CNT_W-1:0]      over_ctr;
        logic [CNT_W-1:0]      limit_ctr;
        logic                  step_flag;
        logic                  over_flag;
        logic                  warn_flag;
    } phase_state_t;

    typedef struct packed {
        logic trip;
        logic go;
    } phase_stat_t;

endpackage

`default_nettype wire

[hdl/tcp_if.sv]
`default_nettype none

interface tcp_in_if #(
    parameter int CURRENT_WIDTH = 16
);
    logic                            valid;
    logic                            ready;
    logic signed [CURRENT_WIDTH-1:0] u_sample;
    logic signed [CURRENT_WIDTH-1:0] v_sample;
    logic signed [CURRENT_WIDTH-1:0] w_sample;
    logic        [CURRENT_WIDTH-1:0] u_rms;
    logic        [CURRENT_WIDTH-1:0] v_rms;
    logic        [CURRENT_WIDTH-1:0] w_rms;
    logic                            fault_clear;

    modport source (
        output valid, u_sample, v_sample, w_sample, u_rms, v_rms, w_rms, fault_clear,
        input  ready
    );
    modport sink (
        input  valid, u_sample, v_sample, w_sample, u_rms, v_rms, w_rms, fault_clear,
        output ready
    );
endinterface

interface tcp_out_if;
    logic valid;
    logic ready;
    logic pwm_stop;
    logic u_step_fault;
    logic v_step_fault;
    logic w_step_fault;
    logic u_over_fault;
    logic v_over_fault;
    logic w_over_fault;
    logic u_limit_warn;
    logic v_limit_warn;
    logic w_limit_warn;

    modport source (
        output valid, pwm_stop, u_step_fault, v_step_fault, w_step_fault,
               u_over_fault, v_over_fault, w_over_fault,
               u_limit_warn, v_limit_warn, w_limit_warn,
        input  ready
    );
    modport sink (
        input  valid, pwm_stop, u_step_fault, v_step_fault, w_step_fault,
               u_over_fault, v_over_fault, w_over_fault,
               u_limit_warn, v_limit_warn, w_limit_warn,
        output ready
    );
endinterface

`default_nettype wire

[hdl/tcp_regs.sv]
`default_nettype none

module tcp_regs
    import tcp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.step_th    <= RST_STEP_TH;
            cfg_reg.over_th    <= RST_OVER_TH;
            cfg_reg.limit_th   <= RST_LIMIT_TH;
            cfg_reg.limit_hyst <= RST_LIMIT_HYST;
            cfg_reg.step_cnt   <= RST_STEP_CNT;
            cfg_reg.over_cnt   <= RST_OVER_CNT;
            cfg_reg.limit_cnt  <= RST_LIMIT_CNT;
        end else if (wr_en) begin
            unique case (idx)
                REG_STEP_TH:    cfg_reg.step_th    <= pwdata[STEP_TH_W-1:0];
                REG_OVER_TH:    cfg_reg.over_th    <= pwdata[LEVEL_W-1:0];
                REG_LIMIT_TH:   cfg_reg.limit_th   <= pwdata[LEVEL_W-1:0];
                REG_LIMIT_HYST: cfg_reg.limit_hyst <= pwdata[LEVEL_W-1:0];
                REG_STEP_CNT:   cfg_reg.step_cnt   <= pwdata[STEP_CNT_W-1:0];
                REG_OVER_CNT:   cfg_reg.over_cnt   <= pwdata[CNT_W-1:0];
                REG_LIMIT_CNT:  cfg_reg.limit_cnt  <= pwdata[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_STEP_TH:    prdata = APB_DATA_W'(cfg_reg.step_th);
            REG_OVER_TH:    prdata = APB_DATA_W'(cfg_reg.over_th);
            REG_LIMIT_TH:   prdata = APB_DATA_W'(cfg_reg.limit_th);
            REG_LIMIT_HYST: prdata = APB_DATA_W'(cfg_reg.limit_hyst);
            REG_STEP_CNT:   prdata = APB_DATA_W'(cfg_reg.step_cnt);
            REG_OVER_CNT:   prdata = APB_DATA_W'(cfg_reg.over_cnt);
            REG_LIMIT_CNT:  prdata = APB_DATA_W'(cfg_reg.limit_cnt);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/tcp_phase.sv]
`default_nettype none

module tcp_phase
    import tcp_pkg::*;
#(
    parameter int CURRENT_WIDTH = 16
)
(
    input  wire logic                            en,
    input  wire logic signed [CURRENT_WIDTH-1:0] sample,
    input  wire logic        [CURRENT_WIDTH-1:0] rms,
    input  wire cfg_t                            cfg,
    input  wire phase_state_t                    cur,
    output phase_state_t                         nxt,
    output phase_stat_t                          stat
);

    localparam int MW = (CURRENT_WIDTH > LEVEL_W) ? CURRENT_WIDTH : LEVEL_W;
    localparam int XW = MW + 1;

    logic [CURRENT_WIDTH-1:0] mag;
    logic [XW-1:0]            mag_x;
    logic [XW-1:0]            rms_x;
    logic [XW-1:0]            rel_sum;
    logic                     step_hit;
    logic                     over_hit;
    logic                     limit_hit;
    logic                     release_ok;
    logic [STEP_CNT_W-1:0]    step_inc;
    logic [CNT_W-1:0]         over_inc;
    logic [CNT_W-1:0]         limit_inc;

    // full-scale negative maps to 2**(CURRENT_WIDTH-1), still fits unsigned
    assign mag   = sample[CURRENT_WIDTH-1] ? (~sample + 1'b1) : sample;
    assign mag_x = XW'(mag);
    assign rms_x = XW'(rms);
    assign rel_sum = rms_x + XW'(cfg.limit_hyst);

    assign step_hit   = mag_x > XW'(cfg.step_th);
    assign over_hit   = rms_x > XW'(cfg.over_th);
    assign limit_hit  = rms_x > XW'(cfg.limit_th);
    assign release_ok = rel_sum < XW'(cfg.limit_th);

    assign step_inc  = (cur.step_ctr == STEP_CTR_MAX) ? cur.step_ctr : cur.step_ctr + 1'b1;
    assign over_inc  = (cur.over_ctr == CTR_MAX) ? cur.over_ctr : cur.over_ctr + 1'b1;
    assign limit_inc = (cur.limit_ctr == CTR_MAX) ? cur.limit_ctr : cur.limit_ctr + 1'b1;

    always_comb
    begin
        nxt  = cur;
        stat = '0;
        if (en) begin
            stat.go = 1'b1;
            if (step_hit) begin
                nxt.step_ctr = step_inc;
                if (step_inc >= cfg.step_cnt) begin
                    nxt.step_ctr  = cfg.step_cnt;
                    nxt.step_flag = 1'b1;
                    nxt.over_flag = 1'b0;
                    nxt.warn_flag = 1'b0;
                    stat.trip     = 1'b1;
                end
            end else begin
                nxt.step_ctr = '0;
                if (cur.step_flag) begin
                    // latched step fault: drop the rest of the item
                    stat.go = 1'b0;
                end else if (over_hit) begin
                    nxt.over_ctr = over_inc;
                    if (over_inc >= cfg.over_cnt) begin
                        nxt.over_ctr  = cfg.over_cnt;
                        nxt.over_flag = 1'b1;
                        nxt.warn_flag = 1'b0;
                        stat.trip     = 1'b1;
                    end
                end else begin
                    nxt.over_ctr = '0;
                    if (cur.over_flag) begin
                        stat.go = 1'b0;
                    end else if (limit_hit) begin
                        nxt.limit_ctr = limit_inc;
                        if (limit_inc >= cfg.limit_cnt) begin
                            nxt.limit_ctr = cfg.limit_cnt;
                            nxt.warn_flag = 1'b1;
                        end
                    end else begin
                        nxt.limit_ctr = '0;
                        if (cur.warn_flag && release_ok) begin
                            nxt.warn_flag = 1'b0;
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

[hdl/three_phase_current_protection.sv]
// Channel  | Dir | Handshake          | Beat contents
// item     | in  | valid/ready        | u/v/w_sample, u/v/w_rms, fault_clear
// result   | out | valid/ready        | pwm_stop, u/v/w step, over and warn flags
// apb      | in  | psel/penable/pready| 7 config registers at 4*index
//
// One beat per cycle sustained while result.ready holds.
// The item is registered, all three phases are evaluated combinationally
// against the protection state, and the result register is loaded.
// Reset clears all counters and flags and loads the register defaults.
// A stalled result holds the evaluation stage; one item waits in the input
// register, so item.ready drops only when both stages are full.
`default_nettype none

module three_phase_current_protection
    import tcp_pkg::*;
#(
    parameter int CURRENT_WIDTH = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    tcp_in_if.sink                     item,
    tcp_out_if.source                  result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t cfg;

    logic                            s1_valid_reg;
    logic signed [CURRENT_WIDTH-1:0] s1_sample_reg [NUM_PHASES];
    logic        [CURRENT_WIDTH-1:0] s1_rms_reg    [NUM_PHASES];
    logic                            s1_clear_reg;

    phase_state_t state_reg [NUM_PHASES];
    phase_state_t state_cur [NUM_PHASES];
    phase_state_t state_next [NUM_PHASES];
    phase_stat_t  stat [NUM_PHASES];
    logic [NUM_PHASES:0] en_chain;

    logic                  out_valid_reg;
    logic                  pwm_stop_reg;
    logic [NUM_PHASES-1:0] step_fault_reg;
    logic [NUM_PHASES-1:0] over_fault_reg;
    logic [NUM_PHASES-1:0] limit_warn_reg;

    logic                  advance;
    logic                  in_beat;
    logic                  trip_any;
    logic [NUM_PHASES-1:0] step_flags;
    logic [NUM_PHASES-1:0] over_flags;
    logic [NUM_PHASES-1:0] warn_flags;
    logic [NUM_PHASES-1:0] step_flags_next;
    logic [NUM_PHASES-1:0] over_flags_next;
    logic [NUM_PHASES-1:0] warn_flags_next;

    tcp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign in_beat    = item.valid && item.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (item.ready) begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_beat) begin
            s1_sample_reg[0] <= item.u_sample;
            s1_sample_reg[1] <= item.v_sample;
            s1_sample_reg[2] <= item.w_sample;
            s1_rms_reg[0]    <= item.u_rms;
            s1_rms_reg[1]    <= item.v_rms;
            s1_rms_reg[2]    <= item.w_rms;
            s1_clear_reg     <= item.fault_clear;
        end
    end

    // clear latched flags ahead of phase U, counters stay
    always_comb
    begin
        for (int p = 0; p < NUM_PHASES; p++) begin
            state_cur[p] = state_reg[p];
            if (s1_clear_reg) begin
                state_cur[p].step_flag = 1'b0;
                state_cur[p].over_flag = 1'b0;
                state_cur[p].warn_flag = 1'b0;
            end
        end
    end

    assign en_chain[0] = 1'b1;

    for (genvar p = 0; p < NUM_PHASES; p++) begin : g_phase
        tcp_phase #(
            .CURRENT_WIDTH (CURRENT_WIDTH)
        ) u_phase (
            .en     (en_chain[p]),
            .sample (s1_sample_reg[p]),
            .rms    (s1_rms_reg[p]),
            .cfg    (cfg),
            .cur    (state_cur[p]),
            .nxt    (state_next[p]),
            .stat   (stat[p])
        );
        assign en_chain[p+1]      = stat[p].go;
        assign step_flags[p]      = state_reg[p].step_flag;
        assign over_flags[p]      = state_reg[p].over_flag;
        assign warn_flags[p]      = state_reg[p].warn_flag;
        assign step_flags_next[p] = state_next[p].step_flag;
        assign over_flags_next[p] = state_next[p].over_flag;
        assign warn_flags_next[p] = state_next[p].warn_flag;
    end

    assign trip_any = stat[0].trip || stat[1].trip || stat[2].trip;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int p = 0; p < NUM_PHASES; p++) begin
                state_reg[p] <= '0;
            end
        end else if (advance) begin
            for (int p = 0; p < NUM_PHASES; p++) begin
                state_reg[p] <= state_next[p];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (result.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            pwm_stop_reg   <= trip_any;
            step_fault_reg <= step_flags_next;
            over_fault_reg <= over_flags_next;
            limit_warn_reg <= warn_flags_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.pwm_stop     = pwm_stop_reg;
    assign result.u_step_fault = step_fault_reg[0];
    assign result.v_step_fault = step_fault_reg[1];
    assign result.w_step_fault = step_fault_reg[2];
    assign result.u_over_fault = over_fault_reg[0];
    assign result.v_over_fault = over_fault_reg[1];
    assign result.w_over_fault = over_fault_reg[2];
    assign result.u_limit_warn = limit_warn_reg[0];
    assign result.v_limit_warn = limit_warn_reg[1];
    assign result.w_limit_warn = limit_warn_reg[2];

    // a pending result always mirrors the live flags
    a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (step_fault_reg == step_flags) && (over_fault_reg == over_flags)
                          && (limit_warn_reg == warn_flags))
        else $error("result flags differ from protection state");

    a_step_over_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (step_flags & over_flags) == '0)
        else $error("step and over fault latched on the same phase");

    a_warn_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (warn_flags & (step_flags | over_flags)) == '0)
        else $error("limit warning set alongside a latched fault");

    a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("evaluated item did not reach the result register");

    a_trip_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && trip_any) |=> ((step_flags | over_flags) != '0))
        else $error("trip without a latched fault");

endmodule

`default_nettype wire

[verif/three_phase_current_protection_checker.sv]
module three_phase_current_protection_checker
    import tcp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    tcp_in_if                          item,
    tcp_out_if                         result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic                  pready,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic                  pwm_stop;
        logic [NUM_PHASES-1:0] step_fault;
        logic [NUM_PHASES-1:0] over_fault;
        logic [NUM_PHASES-1:0] limit_warn;
    } flags_beat_t;

    cfg_t         cfg;
    phase_state_t ps [NUM_PHASES];
    flags_beat_t  expected_flags [$];
    int           failures;
    string        phase_tag [NUM_PHASES] = '{"u", "v", "w"};

    function automatic flags_beat_t advance_protection(
        input logic [NUM_PHASES-1:0][LEVEL_W-1:0] smp,
        input logic [NUM_PHASES-1:0][LEVEL_W-1:0] rms,
        input logic                               clr
    );
        flags_beat_t      r;
        logic [LEVEL_W:0] mag;
        logic             run;
        r   = '0;
        run = 1'b1;
        if (clr)
        begin
            for (int p = 0; p < NUM_PHASES; p++)
            begin
                ps[p].step_flag = 1'b0;
                ps[p].over_flag = 1'b0;
                ps[p].warn_flag = 1'b0;
            end
        end
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (run)
            begin
                // full-scale negative gives 2^(W-1), one above the largest positive
                mag = smp[p][LEVEL_W-1] ? ({1'b0, ~smp[p]} + 1'b1) : {1'b0, smp[p]};
                if (mag > cfg.step_th)
                begin
                    if (ps[p].step_ctr != STEP_CTR_MAX)
                        ps[p].step_ctr = ps[p].step_ctr + 1'b1;
                    if (ps[p].step_ctr >= cfg.step_cnt)
                    begin
                        ps[p].step_ctr  = cfg.step_cnt;
                        r.pwm_stop      = 1'b1;
                        ps[p].step_flag = 1'b1;
                        ps[p].over_flag = 1'b0;
                        ps[p].warn_flag = 1'b0;
                    end
                end
                else
                begin
                    ps[p].step_ctr = '0;
                    if (ps[p].step_flag)
                        run = 1'b0;
                    else if (rms[p] > cfg.over_th)
                    begin
                        if (ps[p].over_ctr != CTR_MAX)
                            ps[p].over_ctr = ps[p].over_ctr + 1'b1;
                        if (ps[p].over_ctr >= cfg.over_cnt)
                        begin
                            ps[p].over_ctr  = cfg.over_cnt;
                            r.pwm_stop      = 1'b1;
                            ps[p].over_flag = 1'b1;
                            ps[p].warn_flag = 1'b0;
                        end
                    end
                    else
                    begin
                        ps[p].over_ctr = '0;
                        if (ps[p].over_flag)
                            run = 1'b0;
                        else if (rms[p] > cfg.limit_th)
                        begin
                            if (ps[p].limit_ctr != CTR_MAX)
                                ps[p].limit_ctr = ps[p].limit_ctr + 1'b1;
                            if (ps[p].limit_ctr >= cfg.limit_cnt)
                            begin
                                ps[p].limit_ctr = cfg.limit_cnt;
                                ps[p].warn_flag = 1'b1;
                            end
                        end
                        else
                        begin
                            ps[p].limit_ctr = '0;
                            // release only once rms sits a full hysteresis below
                            if (ps[p].warn_flag &&
                                ({1'b0, rms[p]} + {1'b0, cfg.limit_hyst} <
                                 {1'b0, cfg.limit_th}))
                                ps[p].warn_flag = 1'b0;
                        end
                    end
                end
            end
        end
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            r.step_fault[p] = ps[p].step_flag;
            r.over_fault[p] = ps[p].over_flag;
            r.limit_warn[p] = ps[p].warn_flag;
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0b, actual %0b", field, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        flags_beat_t seen;
        flags_beat_t want;
        if (!rst_n)
        begin
            cfg.step_th    = RST_STEP_TH;
            cfg.over_th    = RST_OVER_TH;
            cfg.limit_th   = RST_LIMIT_TH;
            cfg.limit_hyst = RST_LIMIT_HYST;
            cfg.step_cnt   = RST_STEP_CNT;
            cfg.over_cnt   = RST_OVER_CNT;
            cfg.limit_cnt  = RST_LIMIT_CNT;
            foreach (ps[p])
                ps[p] = '0;
            expected_flags.delete();
            failures = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_STEP_TH:    cfg.step_th    = pwdata[STEP_TH_W-1:0];
                    REG_OVER_TH:    cfg.over_th    = pwdata[LEVEL_W-1:0];
                    REG_LIMIT_TH:   cfg.limit_th   = pwdata[LEVEL_W-1:0];
                    REG_LIMIT_HYST: cfg.limit_hyst = pwdata[LEVEL_W-1:0];
                    REG_STEP_CNT:   cfg.step_cnt   = pwdata[STEP_CNT_W-1:0];
                    REG_OVER_CNT:   cfg.over_cnt   = pwdata[CNT_W-1:0];
                    REG_LIMIT_CNT:  cfg.limit_cnt  = pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            // compare before predicting so a beat never meets its own item
            if (result.valid && result.ready)
            begin
                seen.pwm_stop   = result.pwm_stop;
                seen.step_fault = {result.w_step_fault, result.v_step_fault,
                                   result.u_step_fault};
                seen.over_fault = {result.w_over_fault, result.v_over_fault,
                                   result.u_over_fault};
                seen.limit_warn = {result.w_limit_warn, result.v_limit_warn,
                                   result.u_limit_warn};
                if (expected_flags.size() == 0)
                begin
                    $error("result beat arrived with no item outstanding");
                    failures++;
                end
                else
                begin
                    want = expected_flags.pop_front();
                    check_field("pwm_stop", want.pwm_stop, seen.pwm_stop);
                    for (int p = 0; p < NUM_PHASES; p++)
                    begin
                        check_field({phase_tag[p], "_step_fault"},
                                    want.step_fault[p], seen.step_fault[p]);
                        check_field({phase_tag[p], "_over_fault"},
                                    want.over_fault[p], seen.over_fault[p]);
                        check_field({phase_tag[p], "_limit_warn"},
                                    want.limit_warn[p], seen.limit_warn[p]);
                    end
                end
            end
            if (item.valid && item.ready)
                expected_flags.push_back(advance_protection(
                    {item.w_sample, item.v_sample, item.u_sample},
                    {item.w_rms, item.v_rms, item.u_rms},
                    item.fault_clear));
            pending    <= expected_flags.size();
            fail_count <= failures;
        end
    end

endmodule

[verif/three_phase_current_protection_tb.sv]
module three_phase_current_protection_tb;
    import tcp_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 85;
    localparam int IDLE_HEAVY      = 88;
    localparam int IDLE_LIGHT      = 20;
    localparam int CLEAR_PCT       = 6;
    localparam logic [2:0] UNMAPPED_REG = 3'd7;

    typedef struct packed {
        logic [NUM_PHASES-1:0][LEVEL_W-1:0] smp;
        logic [NUM_PHASES-1:0][LEVEL_W-1:0] rms;
        logic                               clr;
    } item_beat_t;

    typedef enum int {
        REGIME_QUIET,
        REGIME_STEP,
        REGIME_OVER,
        REGIME_LIMIT,
        REGIME_HYST,
        REGIME_NOISE
    } regime_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   fail_count;
    int   pending;
    int   idle_pct;
    int   stall_pct;
    int   hold_request;
    int   quiet_cycles;
    cfg_t cfg_now;

    tcp_in_if #(.CURRENT_WIDTH(LEVEL_W)) item ();
    tcp_out_if                           result ();

    three_phase_current_protection #(.CURRENT_WIDTH(LEVEL_W)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    three_phase_current_protection_checker protection_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (item.valid && item.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("three_phase_current_protection verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                result.ready <= 1'b0;
                hold_left--;
            end
            else
                result.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic item_beat_t make_beat(input int su, input int sv, input int sw,
                                             input int ru, input int rv, input int rw,
                                             input logic clr);
        item_beat_t b;
        b.smp = {LEVEL_W'(sw), LEVEL_W'(sv), LEVEL_W'(su)};
        b.rms = {LEVEL_W'(rw), LEVEL_W'(rv), LEVEL_W'(ru)};
        b.clr = clr;
        return b;
    endfunction

    function automatic logic [APB_DATA_W-1:0] with_junk(input logic [APB_DATA_W-1:0] v,
                                                        input int w);
        return ({$urandom} << w) | v;
    endfunction

    // pick levels that sit on the chosen side of the live thresholds
    function automatic void shape_levels(input regime_t rg, output logic [LEVEL_W-1:0] smp,
                                         output logic [LEVEL_W-1:0] rms);
        int sth;
        int oth;
        int lth;
        int hys;
        int mag;
        int lo;
        int hi;
        sth = cfg_now.step_th;
        oth = cfg_now.over_th;
        lth = cfg_now.limit_th;
        hys = cfg_now.limit_hyst;
        if (rg == REGIME_NOISE)
        begin
            smp = LEVEL_W'($urandom);
            rms = LEVEL_W'($urandom);
        end
        else if (rg == REGIME_STEP)
        begin
            mag = $urandom_range(32768, sth + 1);
            smp = LEVEL_W'($urandom_range(1) ? -mag : mag);
            rms = LEVEL_W'($urandom);
        end
        else
        begin
            mag = $urandom_range(sth);
            smp = LEVEL_W'($urandom_range(1) ? -mag : mag);
            case (rg)
                REGIME_OVER:
                begin
                    lo  = (oth < 65535) ? oth + 1 : 65535;
                    rms = LEVEL_W'($urandom_range(65535, lo));
                end
                REGIME_LIMIT:
                begin
                    lo  = (lth < 65535) ? lth + 1 : 65535;
                    hi  = (oth > lth) ? oth : 65535;
                    rms = LEVEL_W'($urandom_range(hi, lo));
                end
                REGIME_HYST:
                begin
                    lo  = (lth - hys - 3 > 0) ? lth - hys - 3 : 0;
                    rms = LEVEL_W'($urandom_range(lth, lo));
                end
                default:
                    rms = LEVEL_W'($urandom_range(lth));
            endcase
        end
    endfunction

    task automatic send_item(input item_beat_t b);
        while ($urandom_range(99) < idle_pct)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid       <= 1'b1;
        item.u_sample    <= b.smp[0];
        item.v_sample    <= b.smp[1];
        item.w_sample    <= b.smp[2];
        item.u_rms       <= b.rms[0];
        item.v_rms       <= b.rms[1];
        item.w_rms       <= b.rms[2];
        item.fault_clear <= b.clr;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
    endtask

    // drop valid and hold until every result is back and the pipe is empty
    task automatic drain();
        item.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_config(input cfg_t c);
        apb_write(REG_STEP_TH,    with_junk(c.step_th, STEP_TH_W));
        apb_write(REG_OVER_TH,    with_junk(c.over_th, LEVEL_W));
        apb_write(REG_LIMIT_TH,   with_junk(c.limit_th, LEVEL_W));
        apb_write(REG_LIMIT_HYST, with_junk(c.limit_hyst, LEVEL_W));
        apb_write(REG_STEP_CNT,   with_junk(c.step_cnt, STEP_CNT_W));
        apb_write(REG_OVER_CNT,   with_junk(c.over_cnt, CNT_W));
        apb_write(REG_LIMIT_CNT,  with_junk(c.limit_cnt, CNT_W));
        cfg_now = c;
    endtask

    initial
    begin
        item_beat_t b;
        cfg_t       c;
        regime_t    rg [NUM_PHASES];
        int         rg_left [NUM_PHASES];
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 0;
        quiet_cycles = 0;
        foreach (rg_left[p])
        begin
            rg[p]      = REGIME_QUIET;
            rg_left[p] = 0;
        end
        rst_n            <= 1'b0;
        item.valid       <= 1'b0;
        item.u_sample    <= '0;
        item.v_sample    <= '0;
        item.w_sample    <= '0;
        item.u_rms       <= '0;
        item.v_rms       <= '0;
        item.w_rms       <= '0;
        item.fault_clear <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_now.step_th    = RST_STEP_TH;
        cfg_now.over_th    = RST_OVER_TH;
        cfg_now.limit_th   = RST_LIMIT_TH;
        cfg_now.limit_hyst = RST_LIMIT_HYST;
        cfg_now.step_cnt   = RST_STEP_CNT;
        cfg_now.over_cnt   = RST_OVER_CNT;
        cfg_now.limit_cnt  = RST_LIMIT_CNT;

        // reset settings: only a full-scale negative sample counts as a step
        send_item(make_beat(0, 0, 0, 0, 0, 0, 1'b0));
        send_item(make_beat(32767, 32767, 32767, 65535, 65535, 65535, 1'b0));
        repeat (3) send_item(make_beat(-32768, 32767, -1, 0, 0, 0, 1'b0));
        drain();

        c.step_th    = 1000;
        c.over_th    = 3000;
        c.limit_th   = 2000;
        c.limit_hyst = 100;
        c.step_cnt   = 0;
        c.over_cnt   = 2;
        c.limit_cnt  = 2;
        write_config(c);
        // zero step count: V trips on its first step sample, again after a clear
        send_item(make_beat(0, 1001, 0, 0, 0, 0, 1'b0));
        send_item(make_beat(0, 1001, 0, 0, 0, 0, 1'b1));
        send_item(make_beat(0, 0, 0, 0, 0, 3001, 1'b1));
        send_item(make_beat(0, 0, 0, 2001, 0, 3001, 1'b0));
        send_item(make_beat(0, 0, 0, 2001, 0, 0, 1'b0));
        send_item(make_beat(0, 0, 0, 1950, 0, 0, 1'b0));
        send_item(make_beat(0, 0, 0, 1899, 0, 0, 1'b0));
        send_item(make_beat(-32768, -32768, -32768, 65535, 65535, 65535, 1'b1));
        send_item(make_beat(0, 0, 0, 0, 0, 0, 1'b1));
        send_item(make_beat(-1000, 1000, -1001, 3001, 2001, 0, 1'b0));

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            case (ph)
                1:
                begin
                    c.step_th    = '1;
                    c.over_th    = '1;
                    c.limit_th   = '1;
                    c.limit_hyst = '1;
                    c.step_cnt   = '1;
                    c.over_cnt   = '1;
                    c.limit_cnt  = '1;
                end
                2:
                begin
                    c.step_th    = '0;
                    c.over_th    = '0;
                    c.limit_th   = '0;
                    c.limit_hyst = '0;
                    c.step_cnt   = 1;
                    c.over_cnt   = 1;
                    c.limit_cnt  = 1;
                end
                default:
                begin
                    c.step_th    = STEP_TH_W'($urandom_range(3000));
                    c.over_th    = LEVEL_W'($urandom_range(6000, 1000));
                    c.limit_th   = LEVEL_W'($urandom_range(5000, 500));
                    c.limit_hyst = LEVEL_W'($urandom_range(300));
                    c.step_cnt   = STEP_CNT_W'($urandom_range(15));
                    c.over_cnt   = CNT_W'($urandom_range(6));
                    c.limit_cnt  = CNT_W'($urandom_range(6));
                    // hysteresis above the threshold: warnings never release
                    if (ph == 5)
                        c.limit_hyst = LEVEL_W'($urandom_range(65535, c.limit_th + 1));
                end
            endcase
            write_config(c);
            if (ph == 0)
                apb_write(UNMAPPED_REG, $urandom);
            case (ph % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = IDLE_HEAVY;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = IDLE_HEAVY;
                end
                default:
                begin
                    idle_pct  = IDLE_LIGHT;
                    stall_pct = IDLE_LIGHT;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 0 && n == 20)
                    hold_request = HOLD_OFF_CYCLES;
                if (ph == 3 && n == 40)
                    drain();
                for (int p = 0; p < NUM_PHASES; p++)
                begin
                    if (rg_left[p] == 0)
                    begin
                        case ($urandom_range(8))
                            0, 1:    rg[p] = REGIME_QUIET;
                            2:       rg[p] = REGIME_STEP;
                            3:       rg[p] = REGIME_OVER;
                            4, 5:    rg[p] = REGIME_LIMIT;
                            6, 7:    rg[p] = REGIME_HYST;
                            default: rg[p] = REGIME_NOISE;
                        endcase
                        rg_left[p] = $urandom_range(16, 1);
                    end
                    rg_left[p]--;
                    shape_levels(rg[p], b.smp[p], b.rms[p]);
                end
                b.clr = ($urandom_range(99) < CLEAR_PCT);
                send_item(b);
            end
        end
        drain();

        if (fail_count == 0)
            $display("three_phase_current_protection verification clean");
        else
            $display("three_phase_current_protection verification failed");
        $finish;
    end

endmodule

[three_phase_current_protection.f]
hdl/tcp_pkg.sv
hdl/tcp_if.sv
hdl/tcp_regs.sv
hdl/tcp_phase.sv
hdl/three_phase_current_protection.sv
verif/three_phase_current_protection_checker.sv
verif/three_phase_current_protection_tb.sv
